@@ rtl/ifrd_pkg.sv @@
// Shared types, constants and helpers for the IMU face detect / rotary dimmer block.
`default_nettype none

package ifrd_pkg;

    // Dim store depth (eight slots; face codes -3..3, tie code included, use slots 0..6)
    localparam int FACE_SLOTS = 8;
    localparam int SLOT_W     = $clog2(FACE_SLOTS);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam int SAMPLE_W = 16;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;

    // Dimmer constants, Q15
    localparam logic [15:0]        DIM_FULL     = 16'd32768;
    localparam logic [18:0]        DIM_MIN_STEP = 19'd327;
    localparam logic [15:0]        DIM_LOW      = 16'd1639;
    localparam logic signed [19:0] ROT_MAX      = 20'sd262143;
    localparam logic signed [19:0] ROT_MIN      = -20'sd262144;

    // Face codes: signed axis of the largest accel magnitude
    localparam logic signed [2:0] FACE_NONE = 3'sd0;
    localparam logic signed [2:0] FACE_XP   = 3'sd1;
    localparam logic signed [2:0] FACE_XN   = -3'sd1;
    localparam logic signed [2:0] FACE_YP   = 3'sd2;
    localparam logic signed [2:0] FACE_YN   = -3'sd2;
    localparam logic signed [2:0] FACE_ZP   = 3'sd3;
    localparam logic signed [2:0] FACE_ZN   = -3'sd3;

    // Register reset values
    localparam logic [16:0] GYRO_TOL_RST    = 17'd400;
    localparam logic [14:0] ACCEL_TOL_RST   = 15'd1600;
    localparam logic [15:0] GRAVITY_RST     = 16'd16900;
    localparam logic [14:0] NOISE_FLOOR_RST = 15'd163;
    localparam logic [15:0] STEP_THR_RST    = 16'd1638;
    localparam logic [15:0] SENS_NORM_RST   = 16'd6554;
    localparam logic [15:0] SENS_RED_RST    = 16'd3277;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GYRO_TOL    = 3'd0,
        REG_ACCEL_TOL   = 3'd1,
        REG_GRAVITY     = 3'd2,
        REG_NOISE_FLOOR = 3'd3,
        REG_STEP_THR    = 3'd4,
        REG_SENS_NORM   = 3'd5,
        REG_SENS_RED    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [16:0] gyro_tol;
        logic [14:0] accel_tol;
        logic [15:0] gravity;
        logic [14:0] noise_floor;
        logic [15:0] step_thr;
        logic [15:0] sens_norm;
        logic [15:0] sens_red;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] gyro_z;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } sample_t;

    typedef struct packed {
        logic signed [2:0] face;
        logic              moving;
        logic              not_flat;
    } sense_t;

    // Packed so that face_code sits in the low bits of tdata
    typedef struct packed {
        logic              lights_off;
        logic              feedback_pulse;
        logic [7:0]        led_level;
        logic [15:0]       dim_out;
        logic              not_flat;
        logic              is_moving;
        logic              face_changed;
        logic signed [2:0] face_code;
    } result_t;

    // Magnitude of a 16-bit signed value, 17 bits to hold 32768
    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = {v[15], v};
        return w[16] ? 17'(-w) : 17'(w);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ifrd_cfg_regs.sv @@
// Configuration register file for the face detect / dimmer block.
`default_nettype none

module ifrd_cfg_regs
    import ifrd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gyro_tol    <= GYRO_TOL_RST;
            cfg_reg.accel_tol   <= ACCEL_TOL_RST;
            cfg_reg.gravity     <= GRAVITY_RST;
            cfg_reg.noise_floor <= NOISE_FLOOR_RST;
            cfg_reg.step_thr    <= STEP_THR_RST;
            cfg_reg.sens_norm   <= SENS_NORM_RST;
            cfg_reg.sens_red    <= SENS_RED_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_GYRO_TOL:    cfg_reg.gyro_tol    <= cfg_wdata[16:0];
                REG_ACCEL_TOL:   cfg_reg.accel_tol   <= cfg_wdata[14:0];
                REG_GRAVITY:     cfg_reg.gravity     <= cfg_wdata[15:0];
                REG_NOISE_FLOOR: cfg_reg.noise_floor <= cfg_wdata[14:0];
                REG_STEP_THR:    cfg_reg.step_thr    <= cfg_wdata[15:0];
                REG_SENS_NORM:   cfg_reg.sens_norm   <= cfg_wdata[15:0];
                REG_SENS_RED:    cfg_reg.sens_red    <= cfg_wdata[15:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ifrd_sense.sv @@
// Face pick, gyro motion test and gravity window test for one sample.
`default_nettype none

module ifrd_sense
    import ifrd_pkg::*;
(
    input  wire sample_t smp,
    input  wire cfg_t    cfg,
    output sense_t       sense
);

    logic [16:0]        ax, ay, az, gxa, gya, gza, amax;
    logic [18:0]        gsum;
    logic signed [18:0] lo, hi, mm;

    always_comb begin
        ax  = abs16(smp.accel_x);
        ay  = abs16(smp.accel_y);
        az  = abs16(smp.accel_z);
        gxa = abs16(smp.gyro_x);
        gya = abs16(smp.gyro_y);
        gza = abs16(smp.gyro_z);

        // strict winner only; any shared maximum gives the tie code
        if (ax > ay && ax > az) begin
            sense.face = smp.accel_x[15] ? FACE_XN : FACE_XP;
        end else if (ay > ax && ay > az) begin
            sense.face = smp.accel_y[15] ? FACE_YN : FACE_YP;
        end else if (az > ax && az > ay) begin
            sense.face = smp.accel_z[15] ? FACE_ZN : FACE_ZP;
        end else begin
            sense.face = FACE_NONE;
        end

        gsum = 19'(gxa) + 19'(gya) + 19'(gza);
        sense.moving = gsum > 19'(cfg.gyro_tol);

        amax = ax;
        if (ay > amax) amax = ay;
        if (az > amax) amax = az;

        // window bounds may go negative or past 16 bits
        lo = $signed({3'b000, cfg.gravity}) - $signed({4'b0000, cfg.accel_tol});
        hi = $signed({3'b000, cfg.gravity}) + $signed({4'b0000, cfg.accel_tol});
        mm = $signed({2'b00, amax});
        sense.not_flat = (mm < lo) || (mm > hi);
    end

endmodule

`default_nettype wire

@@ rtl/ifrd_dimmer.sv @@
// Face state, per-face dim store, rotation accumulator and dim step logic.
`default_nettype none

module ifrd_dimmer
    import ifrd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         advance,
    input  wire sense_t       sense,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic signed [15:0] gyro_z,
    input  wire cfg_t         cfg,
    output result_t           res
);

    logic signed [2:0]  cur_face_reg;
    logic [15:0]        dim_reg;
    logic [15:0]        store_reg [FACE_SLOTS];
    logic signed [18:0] rot_sum_reg;
    logic               off_warned_reg, off_flag_reg;

    logic signed [2:0]  cur_face_next;
    logic [15:0]        dim_next;
    logic signed [18:0] rot_sum_next;
    logic               off_warned_next, off_flag_next;

    logic               flat, change, accumulate, passed, do_step, pulse;
    logic [2:0]         old_idx, new_idx;
    logic [SLOT_W-1:0]  old_slot, new_slot;
    logic [15:0]        dim_base, dim_clamped;
    logic signed [16:0] rot;
    logic [16:0]        rot_mag;
    logic signed [19:0] sum_wide;
    logic signed [18:0] sum_acc;
    logic [18:0]        sum_mag;
    logic [15:0]        gain;
    logic signed [35:0] prod, prod_adj;
    logic signed [19:0] delta;
    logic signed [20:0] lvl;
    logic [23:0]        led_wide;

    always_comb begin
        flat   = !sense.not_flat;
        change = flat && (sense.face != cur_face_reg);

        // face code -3..3 maps to slot 0..6, always inside the store
        old_idx  = 3'(cur_face_reg) + 3'd3;
        new_idx  = 3'(sense.face) + 3'd3;
        old_slot = SLOT_W'(old_idx);
        new_slot = SLOT_W'(new_idx);

        cur_face_next = change ? sense.face : cur_face_reg;
        dim_base      = change ? store_reg[new_slot] : dim_reg;

        case (sense.face)
            FACE_XN: rot = {gyro_x[15], gyro_x};
            FACE_XP: rot = -{gyro_x[15], gyro_x};
            FACE_YN: rot = {gyro_y[15], gyro_y};
            FACE_YP: rot = -{gyro_y[15], gyro_y};
            FACE_ZN: rot = {gyro_z[15], gyro_z};
            FACE_ZP: rot = -{gyro_z[15], gyro_z};
            default: rot = '0;
        endcase
        rot_mag = rot[16] ? 17'(-rot) : 17'(rot);

        accumulate = flat && (rot_mag > 17'(cfg.noise_floor));
        sum_wide   = $signed({rot_sum_reg[18], rot_sum_reg}) + $signed({{3{rot[16]}}, rot});
        if (!accumulate) begin
            sum_acc = rot_sum_reg;
        end else if (sum_wide > ROT_MAX) begin
            sum_acc = ROT_MAX[18:0];
        end else if (sum_wide < ROT_MIN) begin
            sum_acc = ROT_MIN[18:0];
        end else begin
            sum_acc = sum_wide[18:0];
        end
        sum_mag = sum_acc[18] ? 19'(-sum_acc) : 19'(sum_acc);

        passed  = flat && (sum_mag > 19'(cfg.step_thr));
        do_step = passed && (sum_mag > DIM_MIN_STEP);

        // gain follows the accepted face, which equals the sample face when flat
        gain = (sense.face == FACE_ZN) ? cfg.sens_red : cfg.sens_norm;
        prod = $signed({{17{sum_acc[18]}}, sum_acc}) * $signed({20'd0, gain});
        // divide by 65536 rounding toward zero
        prod_adj = prod[35] ? prod + 36'sd65535 : prod;
        delta    = prod_adj[35:16];
        lvl      = $signed({5'b00000, dim_base}) + $signed({delta[19], delta});
        if (lvl < 0) begin
            dim_clamped = '0;
        end else if (lvl > $signed({5'b00000, DIM_FULL})) begin
            dim_clamped = DIM_FULL;
        end else begin
            dim_clamped = lvl[15:0];
        end

        dim_next        = dim_base;
        off_warned_next = off_warned_reg;
        off_flag_next   = off_flag_reg;
        pulse           = 1'b0;
        if (do_step) begin
            dim_next = dim_clamped;
            if (dim_clamped < DIM_LOW) begin
                if (off_warned_reg && !off_flag_reg) begin
                    // second low step: lights go off
                    dim_next        = '0;
                    off_flag_next   = 1'b1;
                    off_warned_next = 1'b0;
                end else if (!off_flag_reg) begin
                    // first low step: warn
                    pulse           = 1'b1;
                    off_warned_next = 1'b1;
                end
            end else if (off_flag_reg) begin
                pulse         = 1'b1;
                off_flag_next = 1'b0;
            end
        end

        if (!flat) begin
            rot_sum_next = rot_sum_reg;
        end else if (passed) begin
            rot_sum_next = '0;
        end else begin
            rot_sum_next = sum_acc;
        end

        // 255 * dim >> 15 as shift and subtract
        led_wide = {dim_next, 8'h00} - {8'h00, dim_next};

        res.face_code      = cur_face_next;
        res.face_changed   = change;
        res.is_moving      = sense.moving;
        res.not_flat       = sense.not_flat;
        res.dim_out        = dim_next;
        res.led_level      = led_wide[22:15];
        res.feedback_pulse = pulse;
        res.lights_off     = off_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_face_reg   <= FACE_NONE;
            dim_reg        <= DIM_FULL;
            rot_sum_reg    <= '0;
            off_warned_reg <= 1'b0;
            off_flag_reg   <= 1'b0;
            for (int i = 0; i < FACE_SLOTS; i++) begin
                store_reg[i] <= DIM_FULL;
            end
        end else if (advance) begin
            cur_face_reg   <= cur_face_next;
            dim_reg        <= dim_next;
            rot_sum_reg    <= rot_sum_next;
            off_warned_reg <= off_warned_next;
            off_flag_reg   <= off_flag_next;
            if (change) begin
                store_reg[old_slot] <= dim_reg;
            end
        end
    end

    // warning and off state are exclusive
    a_warn_off_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(off_warned_reg && off_flag_reg))
        else $error("off_warned and off_flag both set");

    a_dim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dim_reg <= DIM_FULL)
        else $error("dim level above full scale");

    a_face_change: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && change |=> cur_face_reg != $past(cur_face_reg))
        else $error("face change did not move the accepted face");

    a_pulse_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pulse |=> $fell(off_flag_reg) || $rose(off_warned_reg))
        else $error("feedback pulse without warn or turn-on");

endmodule

`default_nettype wire

@@ rtl/imu_face_detect_rotary_dimmer.sv @@
// Top level: stream wrapper around the IMU face detector and rotary dimmer.
//
// Usage:
//   s_ channel carries one six-axis IMU sample per beat; m_ channel returns one
//   result beat per sample, in order. A beat moves when tvalid and tready are
//   both high at a rising edge of aclk. cfg_we/cfg_index/cfg_wdata write the
//   seven tuning registers; write only while no sample is in flight.
//
// Timing:
//   An accepted sample lands in the input register; face pick, motion tests,
//   rotation accumulation and the dim-step multiply run in one pass into the
//   result register, which loads whenever the result slot is free or being
//   drained. Throughput is one sample per cycle while m_tready is high, since
//   the per-sample state update (face, dim level, rotation sum) closes in that pass.
//
// Stall and reset:
//   When m_tready is low the result register holds, the input register takes
//   one more sample, and only then s_tready drops. aresetn (synchronous,
//   active low) empties both stages, restores register defaults, sets full
//   brightness in every face slot, and clears the rotation sum and off state.
`default_nettype none

module imu_face_detect_rotary_dimmer
    import ifrd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32],
    // gyro_x[63:48], gyro_y[79:64], gyro_z[95:80]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // face_code[2:0], face_changed[3], is_moving[4], not_flat[5],
    // dim_out[21:6], led_level[29:22], feedback_pulse[30], lights_off[31]
    output logic [OUT_TDATA_W-1:0]      m_tdata,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t    cfg;
    sense_t  sense;
    result_t res;

    sample_t in_reg;
    logic    in_valid_reg, in_valid_next;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    logic    s_accept, advance;

    // the held sample moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= sample_t'(s_tdata);
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    ifrd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ifrd_sense u_sense (
        .smp   (in_reg),
        .cfg   (cfg),
        .sense (sense)
    );

    ifrd_dimmer u_dimmer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .sense   (sense),
        .gyro_x  (in_reg.gyro_x),
        .gyro_y  (in_reg.gyro_y),
        .gyro_z  (in_reg.gyro_z),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);

endmodule

`default_nettype wire
